// ----- sv/mcl_pkg.sv -----
package mcl_pkg;

    localparam int LINES_DEF    = 1024;
    localparam int REQ_TYPE_W   = 3;
    localparam int LINE_INDEX_W = 10;
    localparam int ADDR_W       = 32;
    localparam int MODULE_W     = 4;
    localparam int STATE_W      = 4;
    localparam int BUS_REQ_W    = 2;

    localparam logic [STATE_W-1:0] ST_I  = 4'd0;
    localparam logic [STATE_W-1:0] ST_IS = 4'd1;
    localparam logic [STATE_W-1:0] ST_IM = 4'd2;
    localparam logic [STATE_W-1:0] ST_S  = 4'd3;
    localparam logic [STATE_W-1:0] ST_SM = 4'd4;
    localparam logic [STATE_W-1:0] ST_E  = 4'd5;
    localparam logic [STATE_W-1:0] ST_O  = 4'd6;
    localparam logic [STATE_W-1:0] ST_OM = 4'd7;
    localparam logic [STATE_W-1:0] ST_M  = 4'd8;
    localparam logic [STATE_W-1:0] ST_F  = 4'd9;
    localparam logic [STATE_W-1:0] ST_FM = 4'd10;

    localparam logic [REQ_TYPE_W-1:0] RQ_LOAD  = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] RQ_STORE = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] RQ_GETS  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] RQ_GETM  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] RQ_DATA  = 3'd4;

    localparam logic [BUS_REQ_W-1:0] BUS_NONE = 2'd0;
    localparam logic [BUS_REQ_W-1:0] BUS_GETS = 2'd1;
    localparam logic [BUS_REQ_W-1:0] BUS_GETM = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]   req_type;
        logic [LINE_INDEX_W-1:0] line_index;
        logic [ADDR_W-1:0]       line_addr;
        logic [MODULE_W-1:0]     src_module;
        logic                    shared_in;
    } mcl_req_t;

    typedef struct packed {
        logic [BUS_REQ_W-1:0] bus_request;
        logic                 data_to_proc;
        logic                 data_on_bus;
        logic [MODULE_W-1:0]  data_dest;
        logic                 assert_shared;
        logic [ADDR_W-1:0]    out_addr;
        logic                 miss;
        logic                 silent_upgrade;
        logic                 protocol_error;
        logic [STATE_W-1:0]   new_state;
    } mcl_rsp_t;

endpackage

// ----- sv/moesif_coherence_line_controller.sv -----
// Channel   Direction  Signals                         Payload
// s_        in         s_valid, s_ready, s_data        mcl_req_t, one access, snoop or data fill
// m_        out        m_valid, m_ready, m_data        mcl_rsp_t, one result per item
// cfg_      in         cfg_valid, cfg_ready, cfg_data  own module number
//
// One item per cycle while m_ready and the clearing pass allow; an accepted item passes the
// pipeline register and then the result register. The line state table is a single-port-read,
// single-port-write memory with a registered read; a write from the item ahead is forwarded to the next read.
// After reset a clearing pass writes I to every line, with s_ready low until it ends.
// A full result register with m_ready low holds the stage behind it and s_ready.
module moesif_coherence_line_controller #(
    parameter int LINES = mcl_pkg::LINES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mcl_pkg::mcl_req_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mcl_pkg::mcl_rsp_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcl_pkg::MODULE_W-1:0]  cfg_data
);
    import mcl_pkg::*;

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    logic [STATE_W-1:0] mem [LINES];

    logic                    clearing_reg;
    logic [IDX_W-1:0]        clr_cnt_reg;
    logic [MODULE_W-1:0]     own_id_reg;

    logic                    p_valid_reg;
    mcl_req_t                p_item_reg;
    logic [IDX_W-1:0]        p_idx_reg;
    logic [STATE_W-1:0]      rd_reg;
    logic                    fwd_reg;
    logic [STATE_W-1:0]      fwd_state_reg;

    logic                    m_valid_reg;
    mcl_rsp_t                m_data_reg;

    logic                    accept;
    logic                    p_advance;
    logic [LINE_INDEX_W-1:0] red_idx;
    logic [IDX_W-1:0]        in_idx;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [STATE_W-1:0]      wr_data;

    logic [STATE_W-1:0]      cur;
    logic [STATE_W-1:0]      nxt;
    logic [BUS_REQ_W-1:0]    bus;
    logic                    to_proc;
    logic                    on_bus;
    logic                    assert_sh;
    logic                    miss;
    logic                    silent;
    logic                    err;
    logic                    own;
    logic                    is_store;
    mcl_rsp_t                rsp;

    assign cfg_ready = 1'b1;
    assign p_advance = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clearing_reg && (!p_valid_reg || p_advance);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // fold the line index into the table depth
    always_comb begin
        red_idx = s_data.line_index;
        for (int k = LINE_INDEX_W - 1; k >= 0; k--) begin
            if ((LINES << k) < (1 << LINE_INDEX_W)) begin
                if (32'(red_idx) >= (LINES << k)) begin
                    red_idx = red_idx - LINE_INDEX_W'(LINES << k);
                end
            end
        end
        in_idx = IDX_W'(red_idx);
    end

    always_comb begin
        if (clearing_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = ST_I;
        end else begin
            wr_en   = p_advance;
            wr_addr = p_idx_reg;
            wr_data = nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rd_reg <= mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            own_id_reg   <= '0;
            p_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(LINES - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready) begin
                own_id_reg <= cfg_data;
            end
            if (accept) begin
                p_valid_reg <= 1'b1;
                fwd_reg     <= p_advance && (p_idx_reg == in_idx);
            end else if (p_advance) begin
                p_valid_reg <= 1'b0;
            end
            if (p_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_item_reg    <= s_data;
            p_idx_reg     <= in_idx;
            fwd_state_reg <= nxt;
        end
        if (p_advance) begin
            m_data_reg <= rsp;
        end
    end

    always_comb begin
        cur       = fwd_reg ? fwd_state_reg : rd_reg;
        own       = (p_item_reg.src_module == own_id_reg);
        is_store  = (p_item_reg.req_type == RQ_STORE);
        nxt       = cur;
        bus       = BUS_NONE;
        to_proc   = 1'b0;
        on_bus    = 1'b0;
        assert_sh = 1'b0;
        miss      = 1'b0;
        silent    = 1'b0;
        err       = 1'b0;
        if (p_item_reg.req_type == RQ_LOAD || p_item_reg.req_type == RQ_STORE) begin
            case (cur)
                ST_I: begin
                    bus  = is_store ? BUS_GETM : BUS_GETS;
                    nxt  = is_store ? ST_IM : ST_IS;
                    miss = 1'b1;
                end
                ST_S: begin
                    if (is_store) begin
                        bus  = BUS_GETM;
                        nxt  = ST_SM;
                        miss = 1'b1;
                    end else begin
                        to_proc = 1'b1;
                    end
                end
                ST_E: begin
                    to_proc = 1'b1;
                    if (is_store) begin
                        nxt    = ST_M;
                        silent = 1'b1;
                    end
                end
                ST_O, ST_F: begin
                    if (is_store) begin
                        bus  = BUS_GETM;
                        nxt  = ST_FM;
                        miss = 1'b1;
                    end else begin
                        to_proc = 1'b1;
                    end
                end
                ST_M: begin
                    to_proc = 1'b1;
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end else if (p_item_reg.req_type == RQ_GETS || p_item_reg.req_type == RQ_GETM
                     || p_item_reg.req_type == RQ_DATA) begin
            case (cur)
                ST_I: begin
                end
                ST_IM: begin
                    if (p_item_reg.req_type == RQ_DATA) begin
                        to_proc = 1'b1;
                        nxt     = ST_M;
                    end
                end
                ST_IS: begin
                    if (p_item_reg.req_type == RQ_DATA) begin
                        to_proc = 1'b1;
                        nxt     = p_item_reg.shared_in ? ST_S : ST_E;
                    end
                end
                ST_S: begin
                    if (p_item_reg.req_type == RQ_GETS) begin
                        assert_sh = 1'b1;
                    end else if (p_item_reg.req_type == RQ_GETM) begin
                        nxt = ST_I;
                    end
                end
                ST_O, ST_F, ST_M, ST_E: begin
                    if (p_item_reg.req_type == RQ_GETS) begin
                        assert_sh = 1'b1;
                        on_bus    = 1'b1;
                        if (cur == ST_M) begin
                            nxt = ST_O;
                        end else if (cur == ST_E) begin
                            nxt = ST_F;
                        end
                    end else if (p_item_reg.req_type == RQ_GETM) begin
                        on_bus = 1'b1;
                        nxt    = ST_I;
                    end else if (cur == ST_E) begin
                        err = 1'b1;
                    end
                end
                ST_SM: begin
                    if (p_item_reg.req_type == RQ_GETS) begin
                        assert_sh = 1'b1;
                    end else if (p_item_reg.req_type == RQ_GETM) begin
                        if (!own) begin
                            assert_sh = 1'b1;
                            nxt       = ST_IM;
                        end
                    end else begin
                        to_proc = 1'b1;
                        nxt     = ST_M;
                    end
                end
                ST_OM, ST_FM: begin
                    if (p_item_reg.req_type == RQ_GETS) begin
                        assert_sh = 1'b1;
                        on_bus    = 1'b1;
                    end else if (p_item_reg.req_type == RQ_GETM) begin
                        on_bus = 1'b1;
                        if (!own) begin
                            nxt = ST_IM;
                        end
                    end else begin
                        to_proc = 1'b1;
                        nxt     = ST_M;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end else begin
            err = 1'b1;
        end

        // drop every effect of an illegal item
        if (err) begin
            nxt       = cur;
            bus       = BUS_NONE;
            to_proc   = 1'b0;
            on_bus    = 1'b0;
            assert_sh = 1'b0;
            miss      = 1'b0;
            silent    = 1'b0;
        end

        rsp.bus_request    = bus;
        rsp.data_to_proc   = to_proc;
        rsp.data_on_bus    = on_bus;
        rsp.data_dest      = on_bus ? p_item_reg.src_module : '0;
        rsp.assert_shared  = assert_sh;
        rsp.out_addr       = (bus != BUS_NONE || to_proc || on_bus) ? p_item_reg.line_addr : '0;
        rsp.miss           = miss;
        rsp.silent_upgrade = silent;
        rsp.protocol_error = err;
        rsp.new_state      = nxt;
    end

endmodule
